### hdl/cdq_pkg.sv
// Shared types, constants and command codes for the circular deque.
`timescale 1ns / 1ps

package cdq_pkg;

  // Number of cells in the row, width of one element.
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;

  // Fill count must hold DEPTH itself.
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  // Capacity register width is fixed by the register definition.
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam int unsigned CMD_W  = 3;

  // Result item: ok, is_empty, is_full, front_value, rear_value.
  localparam int unsigned OUT_BITS = 3 + 2 * DATA_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned IN_W     = ((DATA_W + 7) / 8) * 8;
  localparam int unsigned USER_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cdq_cmd_e;

  // Qualified operation broadcast to every cell: at most one bit is set,
  // and only for an accepted item that succeeds.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cdq_op_t;

endpackage

### hdl/circular_deque_ring_buffer.sv
// Top level of the double-ended queue: command decode, fill count, result register.
`timescale 1ns / 1ps
// The result of an item is registered at the edge that accepts it.
// Throughput: one item per cycle while results are taken; the cell row shifts or
//   fills at the edge that accepts the item and the next state feeds the result register directly.
// Reset: all cells empty, fill count zero, capacity 16, no result pending.
// Reset is asynchronous and active low; element data is not reset.

module circular_deque_ring_buffer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // capacity register write
  input  logic                         cfg_we_i,
  input  logic [cdq_pkg::CAP_W-1:0]    cfg_wdata_i,
  // item in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [cdq_pkg::IN_W-1:0]     s_axis_tdata,  // [31:0] value
  input  logic [cdq_pkg::USER_W-1:0]   s_axis_tuser,  // [2:0] cmd
  // result out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [cdq_pkg::OUT_W-1:0]    m_axis_tdata   // [0] ok, [1] is_empty, [2] is_full,
                                                      // [34:3] front_value, [66:35] rear_value
);

  localparam int unsigned CmpW = cdq_pkg::CMP_W;

  logic [cdq_pkg::CAP_W-1:0]  cap_q;
  logic [cdq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                       out_valid_q;
  logic [cdq_pkg::OUT_W-1:0]  out_data_q;

  logic                       accept;
  logic                       full_now, empty_now;
  logic                       full_after, empty_after;
  logic                       ok;
  cdq_pkg::cdq_op_t           op;
  cdq_pkg::cdq_cmd_e          cmd;
  logic [cdq_pkg::DATA_W-1:0] push_data;
  logic [cdq_pkg::DEPTH-1:0]  cell_valid;
  logic [cdq_pkg::DATA_W-1:0] front_next, rear_next;
  logic [cdq_pkg::DATA_W-1:0] front_val, rear_val;

  // Take a new item whenever the result register is free or being drained.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cmd       = cdq_pkg::cdq_cmd_e'(s_axis_tuser[cdq_pkg::CMD_W-1:0]);
  assign push_data = s_axis_tdata[cdq_pkg::DATA_W-1:0];

  // Full when the count reaches the capacity or the physical row size;
  // a capacity of zero keeps the deque full at all times.
  assign full_now  = (CmpW'(count_q) >= CmpW'(cap_q)) ||
                     (CmpW'(count_q) >= CmpW'(cdq_pkg::DEPTH));
  assign empty_now = (count_q == '0);

  always_comb begin
    op      = '0;
    ok      = 1'b0;
    count_d = count_q;
    case (cmd)
      cdq_pkg::CMD_PUSH_FRONT: begin
        ok            = !full_now;
        op.push_front = accept && !full_now;
      end
      cdq_pkg::CMD_PUSH_BACK: begin
        ok           = !full_now;
        op.push_back = accept && !full_now;
      end
      cdq_pkg::CMD_POP_FRONT: begin
        ok           = !empty_now;
        op.pop_front = accept && !empty_now;
      end
      cdq_pkg::CMD_POP_BACK: begin
        ok          = !empty_now;
        op.pop_back = accept && !empty_now;
      end
      cdq_pkg::CMD_QUERY: begin
        ok = 1'b1;
      end
      default: begin
        // unknown command: report state, change nothing
        ok = 1'b0;
      end
    endcase
    if (op.push_front || op.push_back) begin
      count_d = count_q + 1'b1;
    end else if (op.pop_front || op.pop_back) begin
      count_d = count_q - 1'b1;
    end
  end

  cdq_chain u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .push_data_i  (push_data),
    .valid_o      (cell_valid),
    .front_next_o (front_next),
    .rear_next_o  (rear_next)
  );

  // Flags and values describe the state after the operation.
  assign full_after  = (CmpW'(count_d) >= CmpW'(cap_q)) ||
                       (CmpW'(count_d) >= CmpW'(cdq_pkg::DEPTH));
  assign empty_after = (count_d == '0);
  assign front_val   = empty_after ? '1 : front_next;
  assign rear_val    = empty_after ? '1 : rear_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= cdq_pkg::CAP_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until the next accepted item replaces it.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= cdq_pkg::OUT_W'({rear_val, front_val, full_after, empty_after, ok});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The fill count always matches the number of occupied cells.
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) == CmpW'($countones(cell_valid)))
    else $error("fill count differs from occupied cells");

  // Occupied cells form one unbroken run starting at cell 0.
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the front");

  // The count never exceeds the row size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(cdq_pkg::DEPTH))
    else $error("fill count exceeds row size");

  // A successful pop removes exactly one element.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op.pop_front || op.pop_back) |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not lower the fill count by one");

  // An empty result reports all-ones front and rear values.
  a_empty_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |->
      (m_axis_tdata[cdq_pkg::OUT_BITS-1:3] == '1))
    else $error("empty result carries element values");

endmodule

### hdl/cdq_cell.sv
// One storage cell of the deque row: holds one element and its valid bit.
`timescale 1ns / 1ps

module cdq_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cdq_pkg::cdq_op_t            op_i,
  input  logic [cdq_pkg::DATA_W-1:0]  push_data_i,
  input  logic [cdq_pkg::DATA_W-1:0]  left_data_i,
  input  logic                        left_valid_i,
  input  logic [cdq_pkg::DATA_W-1:0]  right_data_i,
  input  logic                        right_valid_i,
  output logic [cdq_pkg::DATA_W-1:0]  data_o,
  output logic                        valid_o,
  output logic [cdq_pkg::DATA_W-1:0]  data_next_o,
  output logic                        valid_next_o
);

  logic [cdq_pkg::DATA_W-1:0] data_q, data_d;
  logic                       valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    if (op_i.push_front) begin
      // shift toward the rear; cell 0 sees the new item on its left
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (op_i.push_back) begin
      // first empty cell takes the item
      if (!valid_q && left_valid_i) begin
        data_d  = push_data_i;
        valid_d = 1'b1;
      end
    end else if (op_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (op_i.pop_back) begin
      // last occupied cell drops its element
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o       = data_q;
  assign valid_o      = valid_q;
  assign data_next_o  = data_d;
  assign valid_next_o = valid_d;

endmodule

### hdl/cdq_chain.sv
// Row of deque cells with front and rear taps on the next state.
`timescale 1ns / 1ps

module cdq_chain (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cdq_pkg::cdq_op_t            op_i,
  input  logic [cdq_pkg::DATA_W-1:0]  push_data_i,
  output logic [cdq_pkg::DEPTH-1:0]   valid_o,
  output logic [cdq_pkg::DATA_W-1:0]  front_next_o,
  output logic [cdq_pkg::DATA_W-1:0]  rear_next_o
);

  logic [cdq_pkg::DATA_W-1:0] data_q  [cdq_pkg::DEPTH];
  logic [cdq_pkg::DATA_W-1:0] data_d  [cdq_pkg::DEPTH];
  logic [cdq_pkg::DEPTH-1:0]  valid_q;
  logic [cdq_pkg::DEPTH-1:0]  valid_d;
  logic [cdq_pkg::DEPTH-1:0]  last_d;

  for (genvar i = 0; i < cdq_pkg::DEPTH; i++) begin : g_cell
    logic [cdq_pkg::DATA_W-1:0] left_data, right_data;
    logic                       left_valid, right_valid;

    if (i == 0) begin : g_head
      // the new item enters from the left edge of the row
      assign left_data  = push_data_i;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_data  = data_q[i-1];
      assign left_valid = valid_q[i-1];
    end

    if (i == cdq_pkg::DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_data  = data_q[i+1];
      assign right_valid = valid_q[i+1];
    end

    cdq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op_i),
      .push_data_i   (push_data_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (data_q[i]),
      .valid_o       (valid_q[i]),
      .data_next_o   (data_d[i]),
      .valid_next_o  (valid_d[i])
    );
  end

  // The rear element sits in the last valid cell of the next state.
  assign last_d = valid_d & ~(valid_d >> 1);

  always_comb begin
    rear_next_o = '0;
    for (int i = 0; i < cdq_pkg::DEPTH; i++) begin
      rear_next_o = rear_next_o | (data_d[i] & {cdq_pkg::DATA_W{last_d[i]}});
    end
  end

  assign front_next_o = data_d[0];
  assign valid_o      = valid_q;

endmodule
